/* rtl/core/tsde_pkg.sv */
package tsde_pkg;

    // Encoding of the min / max field mode
    typedef enum logic [1:0] {
        MODE_ABSENT = 2'd0,
        MODE_FULL   = 2'd1,
        MODE_DELTA  = 2'd2
    } t_mode;

    // Magnitude patterns: +infinity and 2^63
    localparam logic [62:0] INF_MAG   = 63'h7FF0000000000000;
    localparam logic [62:0] TWO63_MAG = 63'h43E0000000000000;

    // Reverse the byte order of a 64-bit word
    function automatic logic [63:0] byte_swap(input logic [63:0] x);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            r[8*i +: 8] = x[8*(7-i) +: 8];
        end
        return r;
    endfunction

    // Value strictly above -2^63, NaN excluded
    function automatic logic min_inside(input logic [63:0] b);
        logic [62:0] m;
        m = b[62:0];
        return (m <= INF_MAG) && (!b[63] || (m < TWO63_MAG));
    endfunction

    // Value strictly below 2^63, NaN excluded
    function automatic logic max_inside(input logic [63:0] b);
        logic [62:0] m;
        m = b[62:0];
        return (m <= INF_MAG) && (b[63] || (m < TWO63_MAG));
    endfunction

endpackage

/* rtl/core/time_series_delta_encoder_top.sv */
// Delta encoder for sensor samples. Each request on the input channel is one
// sample and gives exactly one result on the output channel. A sample with
// record start set is passed through in full; every other sample is coded
// against the sample before it (timestamp and reading deltas only when they
// change, sequence as delta when the last one is nonzero, min/max as
// byte-reversed pattern deltas when both are in bounds). The block takes one
// sample per clock cycle while the output is not stalled; the sample is held
// in the input register, then the delta logic (64-bit subtractions and
// compares) fills the result register, from which the result is presented.
// The delta history updates as a sample moves into the result register, so
// samples in consecutive cycles are coded against each other correctly. A
// stalled output holds its result while one more sample is taken in.
module time_series_delta_encoder_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // sample request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_record_start,
    input  logic [31:0]          i_sample_time,
    input  logic [63:0]          i_reading_bits,
    input  logic [31:0]          i_sequence_number,
    input  logic [63:0]          i_min_bits,
    input  logic [63:0]          i_max_bits,
    // result request channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_is_full_sample,
    output logic                 o_time_present,
    output logic [31:0]          o_time_field,
    output logic                 o_reading_present,
    output logic signed [63:0]   o_reading_field,
    output logic                 o_sequence_present,
    output logic [31:0]          o_sequence_field,
    output logic [1:0]           o_min_mode,
    output logic signed [63:0]   o_min_field,
    output logic [1:0]           o_max_mode,
    output logic signed [63:0]   o_max_field
);
    import tsde_pkg::*;

    // input register
    logic        r_s1_valid;
    logic        r_s1_start;
    logic [31:0] r_s1_time;
    logic [63:0] r_s1_reading;
    logic [31:0] r_s1_seq;
    logic [63:0] r_s1_min;
    logic [63:0] r_s1_max;

    // delta history
    logic [31:0] r_prev_time;
    logic [63:0] r_prev_reading;
    logic [31:0] r_prev_seq;
    logic [63:0] r_prev_min;
    logic [63:0] r_prev_max;
    logic [31:0] r_last_time_delta;
    logic [63:0] r_last_reading_delta;

    // result register
    logic        r_out_valid;
    logic        r_full;
    logic        r_time_present;
    logic [31:0] r_time_field;
    logic        r_reading_present;
    logic [63:0] r_reading_field;
    logic        r_seq_present;
    logic [31:0] r_seq_field;
    t_mode       r_min_mode;
    logic [63:0] r_min_field;
    t_mode       r_max_mode;
    logic [63:0] r_max_field;

    // next values of the result
    logic        n_time_present;
    logic [31:0] n_time_field;
    logic        n_reading_present;
    logic [63:0] n_reading_field;
    logic        n_seq_present;
    logic [31:0] n_seq_field;
    t_mode       n_min_mode;
    logic [63:0] n_min_field;
    t_mode       n_max_mode;
    logic [63:0] n_max_field;

    logic        out_free;
    logic        s1_move;
    logic        in_take;
    logic [31:0] time_delta;
    logic [63:0] reading_delta;
    logic [63:0] min_diff;
    logic [63:0] max_diff;
    logic        time_changed;
    logic        reading_changed;

    // handshake: result register frees up when empty or taken this cycle
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_take    = i_in_valid && o_in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
        if (in_take) begin
            r_s1_start   <= i_record_start;
            r_s1_time    <= i_sample_time;
            r_s1_reading <= i_reading_bits;
            r_s1_seq     <= i_sequence_number;
            r_s1_min     <= i_min_bits;
            r_s1_max     <= i_max_bits;
        end
    end

    // deltas against the previous sample
    assign time_delta      = r_s1_time - r_prev_time;
    assign reading_delta   = byte_swap(r_s1_reading) - byte_swap(r_prev_reading);
    assign min_diff        = byte_swap(r_s1_min) - byte_swap(r_prev_min);
    assign max_diff        = byte_swap(r_s1_max) - byte_swap(r_prev_max);
    assign time_changed    = time_delta != r_last_time_delta;
    assign reading_changed = reading_delta != r_last_reading_delta;

    // result encoding; absent parts read as zero
    always_comb begin
        n_time_present    = 1'b0;
        n_time_field      = '0;
        n_reading_present = 1'b0;
        n_reading_field   = '0;
        n_seq_present     = 1'b0;
        n_seq_field       = '0;
        n_min_mode        = MODE_ABSENT;
        n_min_field       = '0;
        n_max_mode        = MODE_ABSENT;
        n_max_field       = '0;
        if (r_s1_seq != '0) begin
            n_seq_present = 1'b1;
            n_seq_field   = (r_s1_start || r_prev_seq == '0) ? r_s1_seq
                                                             : r_s1_seq - r_prev_seq;
        end
        if (r_s1_start) begin
            n_time_present    = 1'b1;
            n_time_field      = r_s1_time;
            n_reading_present = 1'b1;
            n_reading_field   = r_s1_reading;
        end else begin
            if (time_changed) begin
                n_time_present = 1'b1;
                n_time_field   = time_delta;
            end
            if (reading_changed) begin
                n_reading_present = 1'b1;
                n_reading_field   = reading_delta;
            end
        end
        if (min_inside(r_s1_min)) begin
            if (!r_s1_start && min_inside(r_prev_min)) begin
                n_min_mode  = MODE_DELTA;
                n_min_field = min_diff;
            end else begin
                n_min_mode  = MODE_FULL;
                n_min_field = r_s1_min;
            end
        end
        if (max_inside(r_s1_max)) begin
            if (!r_s1_start && max_inside(r_prev_max)) begin
                n_max_mode  = MODE_DELTA;
                n_max_field = max_diff;
            end else begin
                n_max_mode  = MODE_FULL;
                n_max_field = r_s1_max;
            end
        end
    end

    // delta history, updated as a sample enters the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time          <= '0;
            r_prev_reading       <= '0;
            r_prev_seq           <= '0;
            r_prev_min           <= '0;
            r_prev_max           <= '0;
            r_last_time_delta    <= '0;
            r_last_reading_delta <= '0;
        end else if (s1_move) begin
            r_prev_time    <= r_s1_time;
            r_prev_reading <= r_s1_reading;
            r_prev_seq     <= r_s1_seq;
            r_prev_min     <= r_s1_min;
            r_prev_max     <= r_s1_max;
            if (r_s1_start) begin
                r_last_time_delta    <= '0;
                r_last_reading_delta <= '0;
            end else begin
                if (time_changed) begin
                    r_last_time_delta <= time_delta;
                end
                if (reading_changed) begin
                    r_last_reading_delta <= reading_delta;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
        if (s1_move) begin
            r_full            <= r_s1_start;
            r_time_present    <= n_time_present;
            r_time_field      <= n_time_field;
            r_reading_present <= n_reading_present;
            r_reading_field   <= n_reading_field;
            r_seq_present     <= n_seq_present;
            r_seq_field       <= n_seq_field;
            r_min_mode        <= n_min_mode;
            r_min_field       <= n_min_field;
            r_max_mode        <= n_max_mode;
            r_max_field       <= n_max_field;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_is_full_sample   = r_full;
    assign o_time_present     = r_time_present;
    assign o_time_field       = r_time_field;
    assign o_reading_present  = r_reading_present;
    assign o_reading_field    = $signed(r_reading_field);
    assign o_sequence_present = r_seq_present;
    assign o_sequence_field   = r_seq_field;
    assign o_min_mode         = r_min_mode;
    assign o_min_field        = $signed(r_min_field);
    assign o_max_mode         = r_max_mode;
    assign o_max_field        = $signed(r_max_field);

    // a full sample always carries time and reading
    a_full_has_time_reading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_full |-> r_time_present && r_reading_present)
        else $error("full sample without time or reading");

    // a sent time delta becomes the new reference
    a_time_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && !r_s1_start && n_time_present |=> r_last_time_delta == r_time_field)
        else $error("time delta history not updated");

    // input stalls only when both registers are full and the output is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_s1_valid && r_out_valid && !i_out_ready)
        else $error("input stalled without cause");

endmodule

/* tb/time_series_delta_encoder_top_tb.sv */
module time_series_delta_encoder_top_tb;
    import tsde_pkg::*;

    localparam int          HALF_PERIOD = 5;
    localparam int          RAND_ITEMS  = 750;
    localparam logic [62:0] MAG_INF     = 63'h7FF0000000000000;
    localparam logic [62:0] MAG_2P63    = 63'h43E0000000000000;

    // Interesting double patterns around the sentinel bounds
    localparam logic [63:0] D_POS_INF   = 64'h7FF0000000000000;
    localparam logic [63:0] D_NEG_INF   = 64'hFFF0000000000000;
    localparam logic [63:0] D_POS_2P63  = 64'h43E0000000000000;
    localparam logic [63:0] D_NEG_2P63  = 64'hC3E0000000000000;
    localparam logic [63:0] D_BELOW_2P63 = 64'h43DFFFFFFFFFFFFF;
    localparam logic [63:0] D_ABOVE_N2P63 = 64'hC3DFFFFFFFFFFFFF;
    localparam logic [63:0] D_QNAN      = 64'h7FF8000000000000;
    localparam logic [63:0] D_NEG_QNAN  = 64'hFFF8000000000000;
    localparam logic [63:0] D_SNAN      = 64'h7FF0000000000001;
    localparam logic [63:0] D_NEG_ZERO  = 64'h8000000000000000;
    localparam logic [63:0] D_ONE       = 64'h3FF0000000000000;

    typedef struct packed {
        logic        start;
        logic [31:0] stamp;
        logic [63:0] reading;
        logic [31:0] seq;
        logic [63:0] lo;
        logic [63:0] hi;
    } t_sample;

    typedef struct packed {
        logic        full;
        logic        t_pres;
        logic [31:0] t_val;
        logic        r_pres;
        logic [63:0] r_val;
        logic        s_pres;
        logic [31:0] s_val;
        t_mode       lo_mode;
        logic [63:0] lo_val;
        t_mode       hi_mode;
        logic [63:0] hi_val;
    } t_coded;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_record_start = 1'b0;
    logic [31:0] i_sample_time = '0;
    logic [63:0] i_reading_bits = '0;
    logic [31:0] i_sequence_number = '0;
    logic [63:0] i_min_bits = '0;
    logic [63:0] i_max_bits = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_is_full_sample;
    logic        o_time_present;
    logic [31:0] o_time_field;
    logic        o_reading_present;
    logic signed [63:0] o_reading_field;
    logic        o_sequence_present;
    logic [31:0] o_sequence_field;
    logic [1:0]  o_min_mode;
    logic signed [63:0] o_min_field;
    logic [1:0]  o_max_mode;
    logic signed [63:0] o_max_field;

    time_series_delta_encoder_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_record_start     (i_record_start),
        .i_sample_time      (i_sample_time),
        .i_reading_bits     (i_reading_bits),
        .i_sequence_number  (i_sequence_number),
        .i_min_bits         (i_min_bits),
        .i_max_bits         (i_max_bits),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_is_full_sample   (o_is_full_sample),
        .o_time_present     (o_time_present),
        .o_time_field       (o_time_field),
        .o_reading_present  (o_reading_present),
        .o_reading_field    (o_reading_field),
        .o_sequence_present (o_sequence_present),
        .o_sequence_field   (o_sequence_field),
        .o_min_mode         (o_min_mode),
        .o_min_field        (o_min_field),
        .o_max_mode         (o_max_mode),
        .o_max_field        (o_max_field)
    );

    // Pending samples, expected coded results, bookkeeping
    t_sample     pending_samples[$];
    t_coded      expected_codes[$];
    t_sample     cur_sample = '0;
    int          total_samples;
    int          samples_taken = 0;
    int          errors = 0;
    logic        live = 1'b0;
    logic        in_fire = 1'b0;
    logic        hold_rx;

    // Encoder history kept by the predictor
    logic [31:0] hist_time = '0;
    logic [63:0] hist_reading = '0;
    logic [31:0] hist_seq = '0;
    logic [63:0] hist_lo = '0;
    logic [63:0] hist_hi = '0;
    logic [31:0] sent_time_step = '0;
    logic [63:0] sent_reading_step = '0;

    // Clock
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic logic [63:0] rev_bytes(input logic [63:0] x);
        logic [63:0] r;
        r = {<<8{x}};
        return r;
    endfunction

    // Strictly above -2^63, NaN excluded
    function automatic logic lo_bounded(input logic [63:0] b);
        if (b[62:0] > MAG_INF) return 1'b0;
        return !b[63] || (b[62:0] < MAG_2P63);
    endfunction

    // Strictly below 2^63, NaN excluded
    function automatic logic hi_bounded(input logic [63:0] b);
        if (b[62:0] > MAG_INF) return 1'b0;
        return b[63] || (b[62:0] < MAG_2P63);
    endfunction

    // Predict the coded result of one sample and advance the history
    function automatic t_coded encode_sample(input t_sample s);
        t_coded      c;
        logic [31:0] t_step;
        logic [63:0] r_step;
        c = '0;
        c.lo_mode = MODE_ABSENT;
        c.hi_mode = MODE_ABSENT;
        if (s.start) begin
            sent_time_step    = '0;
            sent_reading_step = '0;
            c.full   = 1'b1;
            c.t_pres = 1'b1;
            c.t_val  = s.stamp;
            c.r_pres = 1'b1;
            c.r_val  = s.reading;
            if (s.seq != 0) begin
                c.s_pres = 1'b1;
                c.s_val  = s.seq;
            end
            if (lo_bounded(s.lo)) begin
                c.lo_mode = MODE_FULL;
                c.lo_val  = s.lo;
            end
            if (hi_bounded(s.hi)) begin
                c.hi_mode = MODE_FULL;
                c.hi_val  = s.hi;
            end
        end else begin
            t_step = s.stamp - hist_time;
            r_step = rev_bytes(s.reading) - rev_bytes(hist_reading);
            if (t_step != sent_time_step) begin
                sent_time_step = t_step;
                c.t_pres = 1'b1;
                c.t_val  = t_step;
            end
            if (r_step != sent_reading_step) begin
                sent_reading_step = r_step;
                c.r_pres = 1'b1;
                c.r_val  = r_step;
            end
            if (s.seq != 0) begin
                c.s_pres = 1'b1;
                c.s_val  = (hist_seq != 0) ? s.seq - hist_seq : s.seq;
            end
            if (lo_bounded(s.lo)) begin
                if (lo_bounded(hist_lo)) begin
                    c.lo_mode = MODE_DELTA;
                    c.lo_val  = rev_bytes(s.lo) - rev_bytes(hist_lo);
                end else begin
                    c.lo_mode = MODE_FULL;
                    c.lo_val  = s.lo;
                end
            end
            if (hi_bounded(s.hi)) begin
                if (hi_bounded(hist_hi)) begin
                    c.hi_mode = MODE_DELTA;
                    c.hi_val  = rev_bytes(s.hi) - rev_bytes(hist_hi);
                end else begin
                    c.hi_mode = MODE_FULL;
                    c.hi_val  = s.hi;
                end
            end
        end
        hist_time    = s.stamp;
        hist_reading = s.reading;
        hist_seq     = s.seq;
        hist_lo      = s.lo;
        hist_hi      = s.hi;
        return c;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h expected %h", $time, what, got, want);
        errors++;
    endtask

    task automatic push_sample(input logic st, input logic [31:0] ts, input logic [63:0] rd,
                               input logic [31:0] sq, input logic [63:0] lo,
                               input logic [63:0] hi);
        t_sample s;
        s.start   = st;
        s.stamp   = ts;
        s.reading = rd;
        s.seq     = sq;
        s.lo      = lo;
        s.hi      = hi;
        pending_samples.push_back(s);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Double pattern for min/max: bound corners, ordinary values or noise
    function automatic logic [63:0] pick_double();
        int k;
        k = $urandom_range(0, 19);
        case (k)
            0:  return D_POS_INF;
            1:  return D_NEG_INF;
            2:  return D_POS_2P63;
            3:  return D_NEG_2P63;
            4:  return D_BELOW_2P63;
            5:  return D_ABOVE_N2P63;
            6:  return D_QNAN;
            7:  return D_SNAN | {12'h000, 20'h0, $urandom};
            8:  return D_NEG_ZERO;
            9:  return rand64();
            10: return {1'b1, 11'h43E, 20'h0, $urandom};
            11: return {1'b0, 11'h43E, 20'h0, $urandom};
            default: return {$urandom_range(0, 1) == 1, 11'h3F0 + 11'($urandom_range(0, 40)),
                             20'($urandom), $urandom};
        endcase
    endfunction

    // Build the whole stimulus list
    task automatic build_stimulus();
        logic [31:0] ts;
        logic [31:0] t_step;
        logic [63:0] rv;
        logic [63:0] r_step;
        logic [31:0] sq;
        int          made;
        int          len;
        // Directed: delta before any record is opened
        push_sample(1'b0, 32'd5, D_ONE, 32'd0, 64'd0, 64'd0);
        push_sample(1'b0, 32'd5, D_ONE, 32'd3, D_NEG_ZERO, 64'd0);
        // Full sample at the field extremes, min/max outside bounds
        push_sample(1'b1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                    D_NEG_INF, D_POS_INF);
        // Wrapping time and sequence; min/max back inside, so sent in full
        push_sample(1'b0, 32'd3, 64'd0, 32'd1, D_ABOVE_N2P63, D_BELOW_2P63);
        push_sample(1'b0, 32'd11, 64'h0100_0000_0000_0000, 32'd0, D_NEG_2P63, D_POS_2P63);
        // Same time and reading steps: both omitted
        push_sample(1'b0, 32'd19, 64'h0200_0000_0000_0000, 32'd7, D_POS_INF, D_NEG_INF);
        push_sample(1'b0, 32'd27, 64'h0300_0000_0000_0000, 32'd9, 64'd0, 64'd0);
        push_sample(1'b0, 32'd40, 64'h0300_0000_0000_0000, 32'd2, 64'hFFFF_FFFF_FFFF_FFFF,
                    64'h7FFF_FFFF_FFFF_FFFF);
        // NaNs on both sides in a full sample with zero sequence
        push_sample(1'b1, 32'd0, 64'd0, 32'd0, D_QNAN, D_NEG_QNAN);
        push_sample(1'b0, 32'd0, 64'd0, 32'd0, D_SNAN, D_QNAN);
        push_sample(1'b0, 32'hFFFF_FFFF, 64'h8000_0000_0000_0000, 32'h8000_0000,
                    D_NEG_ZERO, D_BELOW_2P63);
        push_sample(1'b1, 32'h8000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 32'd1, 64'd0, D_NEG_INF);
        push_sample(1'b0, 32'h8000_0001, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF,
                    D_ABOVE_N2P63, D_NEG_ZERO);
        push_sample(1'b0, 32'h8000_0002, 64'h0000_0000_0000_0080, 32'd0, D_POS_2P63,
                    D_NEG_2P63);
        push_sample(1'b1, 32'd100, D_ONE, 32'd50, D_NEG_2P63, D_POS_2P63);
        push_sample(1'b0, 32'd100, D_ONE, 32'd51, D_ABOVE_N2P63, D_BELOW_2P63);

        // Random: mostly well-formed records, some noise
        made = 0;
        while (made < RAND_ITEMS) begin
            if ($urandom_range(0, 99) < 12) begin
                push_sample(1'($urandom_range(0, 1)), $urandom, rand64(), $urandom,
                            rand64(), rand64());
                made++;
            end else begin
                ts     = $urandom;
                t_step = $urandom_range(1, 1000);
                rv     = rand64();
                r_step = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 5000));
                sq     = ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom;
                len    = $urandom_range(1, 24);
                for (int i = 0; i < len; i++) begin
                    if (i > 0) begin
                        // mostly steady steps, with jitter and jumps
                        if ($urandom_range(0, 9) < 2) t_step = $urandom_range(0, 1000);
                        if ($urandom_range(0, 29) == 0) t_step = $urandom;
                        ts = ts + t_step;
                        if ($urandom_range(0, 9) < 2) r_step = 64'($urandom_range(0, 5000));
                        if ($urandom_range(0, 19) == 0) r_step = rand64();
                        rv = rv + r_step;
                        case ($urandom_range(0, 19))
                            0, 1:    sq = 32'd0;
                            2:       sq = $urandom;
                            default: sq = sq + 1;
                        endcase
                    end
                    push_sample(i == 0, ts, rev_bytes(rv), sq, pick_double(), pick_double());
                end
                made += len;
            end
        end
    endtask

    // Idle rates by phase of the run
    function automatic int tx_idle_pct();
        if (samples_taken * 3 < total_samples) return 17;
        if (samples_taken * 3 < total_samples * 2) return 57;
        return 0;
    endfunction

    function automatic int rx_idle_pct();
        if (samples_taken * 3 < total_samples) return 57;
        if (samples_taken * 3 < total_samples * 2) return 17;
        return 0;
    endfunction

    // Driver: request channel and result ready, changed on the falling edge
    always @(negedge i_clk) begin
        if (live) begin
            if (!i_in_valid || in_fire) begin
                if (pending_samples.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct()) begin
                    cur_sample = pending_samples.pop_front();
                    i_in_valid        <= 1'b1;
                    i_record_start    <= cur_sample.start;
                    i_sample_time     <= cur_sample.stamp;
                    i_reading_bits    <= cur_sample.reading;
                    i_sequence_number <= cur_sample.seq;
                    i_min_bits        <= cur_sample.lo;
                    i_max_bits        <= cur_sample.hi;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= !hold_rx && ($urandom_range(0, 99) >= rx_idle_pct());
        end
    end

    // Monitor: accepted requests feed the predictor, results are checked
    always @(posedge i_clk) begin
        t_coded want;
        live    <= i_rst_n;
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            expected_codes.push_back(encode_sample(cur_sample));
            samples_taken++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_codes.size() == 0) begin
                report("unexpected result", 64'(o_time_field), 64'd0);
            end else begin
                want = expected_codes.pop_front();
                if (o_is_full_sample !== want.full)
                    report("is_full_sample", 64'(o_is_full_sample), 64'(want.full));
                if (o_time_present !== want.t_pres)
                    report("time_present", 64'(o_time_present), 64'(want.t_pres));
                if (o_time_field !== want.t_val)
                    report("time_field", 64'(o_time_field), 64'(want.t_val));
                if (o_reading_present !== want.r_pres)
                    report("reading_present", 64'(o_reading_present), 64'(want.r_pres));
                if (o_reading_field !== want.r_val)
                    report("reading_field", o_reading_field, want.r_val);
                if (o_sequence_present !== want.s_pres)
                    report("sequence_present", 64'(o_sequence_present), 64'(want.s_pres));
                if (o_sequence_field !== want.s_val)
                    report("sequence_field", 64'(o_sequence_field), 64'(want.s_val));
                if (o_min_mode !== want.lo_mode)
                    report("min_mode", 64'(o_min_mode), 64'(want.lo_mode));
                if (o_min_field !== want.lo_val)
                    report("min_field", o_min_field, want.lo_val);
                if (o_max_mode !== want.hi_mode)
                    report("max_mode", 64'(o_max_mode), 64'(want.hi_mode));
                if (o_max_field !== want.hi_val)
                    report("max_field", o_max_field, want.hi_val);
            end
        end
    end

    // Long receiver stall while the sender keeps offering
    initial begin
        hold_rx = 1'b0;
        while (samples_taken < 120) @(posedge i_clk);
        hold_rx = 1'b1;
        repeat (80) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    // Run limit
    initial begin
        #3000000;
        $display("time_series_delta_encoder_top verification failed");
        $finish;
    end

    // Reset, stimulus and end of run
    initial begin
        i_rst_n = 1'b0;
        build_stimulus();
        total_samples = pending_samples.size();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drain: all requests taken, all results seen, then a wait before the verdict
        while (pending_samples.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_codes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (errors == 0) begin
            $display("time_series_delta_encoder_top verification clean");
        end else begin
            $display("time_series_delta_encoder_top verification failed");
        end
        $finish;
    end

endmodule
